// ----- sv/psin_pkg.sv -----
// Shared types, fixed-point constants and the coefficient table of the polynomial sine.
package psin_pkg;

    localparam int ANGLE_W   = 32;
    localparam int SINE_W    = 32;
    localparam int WORD_W    = 64;
    localparam int HALF_W    = WORD_W / 2;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int FRAC      = 58;
    localparam int OUT_SHIFT = FRAC - 30;

    // Five restoring steps reduce any |angle| below 2^7 rad modulo 2*pi.
    localparam int RED_STEPS = 5;

    localparam int DEF_TERMS = 6;
    localparam int MAX_TERMS = 8;
    localparam int COEF_IDX_W = $clog2(MAX_TERMS);

    typedef logic signed [WORD_W-1:0] t_q58;
    typedef logic        [WORD_W-1:0] t_word;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_tag;

    localparam t_word TWO_PI_Q56 = 64'h06487ED5110B4612;
    localparam t_word PI_Q56     = 64'h03243F6A8885A309;
    localparam t_q58  PI_Q58     = 64'sh0C90FDAA22168C23;
    localparam t_q58  D_Q58      = PI_Q58 - 64'sd25197900088;

    localparam logic        [SINE_W-2:0] ONE_Q30  = 31'h4000_0000;
    localparam logic signed [SINE_W-1:0] SINE_MAX = {1'b0, ONE_Q30};
    localparam logic signed [SINE_W-1:0] SINE_MIN = -SINE_MAX;

    // Horner coefficients in Q5.58, highest power first.
    function automatic t_q58 psin_coef(input logic [COEF_IDX_W-1:0] idx);
        t_q58 c;
        case (idx)
            3'd2:    c = 64'sd38309693;
            3'd3:    c = -64'sd6720895302;
            3'd4:    c = 64'sd727001274970;
            3'd5:    c = -64'sd50009428106339;
            3'd6:    c = 64'sd1908338595025865;
            3'd7:    c = -64'sd29203842788201886;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/psin_mul.sv -----
// Two-stage signed Q5.58 multiplier, rounded to nearest with ties away from zero.
module psin_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psin_pkg::t_tag i_tag,
    input  psin_pkg::t_q58 i_a,
    input  psin_pkg::t_q58 i_b,
    output psin_pkg::t_tag o_tag,
    output psin_pkg::t_q58 o_p
);
    import psin_pkg::*;

    t_word             ua;
    t_word             ub;
    t_word             n_p0;
    t_word             n_p1;
    t_word             n_p2;
    t_word             n_p3;
    t_word             r_p0;
    t_word             r_p1;
    t_word             r_p2;
    t_word             r_p3;
    logic              r_neg;
    t_tag              r_tag1;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] rnd;
    t_word             mag;
    t_q58              n_p;
    t_q58              r_p;
    t_tag              r_tag2;

    // Stage 1: magnitudes and four 32x32 partial products.
    always_comb begin
        ua   = i_a[WORD_W-1] ? $unsigned(-i_a) : $unsigned(i_a);
        ub   = i_b[WORD_W-1] ? $unsigned(-i_b) : $unsigned(i_b);
        n_p0 = ua[HALF_W-1:0]      * ub[HALF_W-1:0];
        n_p1 = ua[HALF_W-1:0]      * ub[WORD_W-1:HALF_W];
        n_p2 = ua[WORD_W-1:HALF_W] * ub[HALF_W-1:0];
        n_p3 = ua[WORD_W-1:HALF_W] * ub[WORD_W-1:HALF_W];
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= n_p0;
        r_p1  <= n_p1;
        r_p2  <= n_p2;
        r_p3  <= n_p3;
        r_neg <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
        if (!i_rst_n) begin
            r_tag1 <= '0;
        end else begin
            r_tag1 <= i_tag;
        end
    end

    // Stage 2: sum, round at the binary point, keep 63 bits, restore sign.
    always_comb begin
        sum = PROD_W'(r_p0)
            + (PROD_W'(r_p1) << HALF_W)
            + (PROD_W'(r_p2) << HALF_W)
            + (PROD_W'(r_p3) << WORD_W);
        rnd = sum + (PROD_W'(1) << (FRAC - 1));
        mag = {1'b0, rnd[FRAC+WORD_W-2:FRAC]};
        n_p = r_neg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
        if (!i_rst_n) begin
            r_tag2 <= '0;
        end else begin
            r_tag2 <= r_tag1;
        end
    end

    assign o_p   = r_p;
    assign o_tag = r_tag2;

endmodule

// ----- sv/psin_red_cell.sv -----
// One restoring step of the angle reduction: subtract the divisor if it fits.
module psin_red_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psin_pkg::t_tag  i_tag,
    input  psin_pkg::t_word i_rem,
    input  psin_pkg::t_word i_div,
    output psin_pkg::t_tag  o_tag,
    output psin_pkg::t_word o_rem
);
    import psin_pkg::*;

    t_word n_rem;
    t_word r_rem;
    t_tag  r_tag;

    assign n_rem = (i_rem >= i_div) ? i_rem - i_div : i_rem;

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    assign o_rem = r_rem;
    assign o_tag = r_tag;

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag.valid |-> (r_rem < i_div))
        else $error("reduction step left a remainder not below its divisor");
`endif

endmodule

// ----- sv/psin_horner_cell.sv -----
// One Horner step v <- v*q + c, carrying q, w and the tag to the next cell.
module psin_horner_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  psin_pkg::t_tag i_tag,
    input  psin_pkg::t_q58 i_v,
    input  psin_pkg::t_q58 i_q,
    input  psin_pkg::t_q58 i_w,
    input  psin_pkg::t_q58 i_coef,
    output psin_pkg::t_tag o_tag,
    output psin_pkg::t_q58 o_v,
    output psin_pkg::t_q58 o_q,
    output psin_pkg::t_q58 o_w
);
    import psin_pkg::*;

    t_tag mul_tag;
    t_q58 prod;
    t_q58 r_q1;
    t_q58 r_q2;
    t_q58 r_q3;
    t_q58 r_w1;
    t_q58 r_w2;
    t_q58 r_w3;
    t_q58 r_v;
    t_tag r_tag;

    psin_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (i_tag),
        .i_a     (i_v),
        .i_b     (i_q),
        .o_tag   (mul_tag),
        .o_p     (prod)
    );

    always_ff @(posedge i_clk) begin
        r_q1 <= i_q;
        r_q2 <= r_q1;
        r_q3 <= r_q2;
        r_w1 <= i_w;
        r_w2 <= r_w1;
        r_w3 <= r_w2;
        r_v  <= prod + i_coef;
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= mul_tag;
        end
    end

    assign o_tag = r_tag;
    assign o_v   = r_v;
    assign o_q   = r_q3;
    assign o_w   = r_w3;

endmodule

// ----- sv/polynomial_sine.sv -----
// Top level of the pipelined polynomial sine: Q8.24 angle in, Q2.30 sine out.
//
//  channel   direction  handshake          payload
//  -------   ---------  -----------------  -------------------------------
//  command   in         start / busy       i_angle  signed Q8.24 radians
//  result    out        o_strobe (1 cycle) o_sine   signed Q2.30, |x| <= 1
//
//  A transaction is taken every cycle: busy is tied low, so start alone accepts.
//  The pipeline depth grows with TERMS: the Horner chain holds TERMS cells,
//  three stages each, ahead of the final product and output rounding.
//  Synchronous active-low reset drops every transaction in flight; datapath
//  registers carry no reset, only the tags do (in this file, their valid bits).
//  The receiver cannot stall: each o_strobe pulse must be taken on that edge.
module polynomial_sine #(
    parameter int TERMS = psin_pkg::DEF_TERMS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [psin_pkg::ANGLE_W-1:0] i_angle,
    output logic                                o_strobe,
    output logic signed [psin_pkg::SINE_W-1:0]  o_sine
);
    import psin_pkg::*;

    localparam int LATENCY = 15 + 3 * TERMS;

    logic accept;

    // Input stage: sign and magnitude (the most negative angle maps to 2^31).
    logic [ANGLE_W-1:0] n_mag;
    logic [ANGLE_W-1:0] r_mag;
    t_tag               r_tag0;

    // Reduction chain.
    t_tag  red_tag [0:RED_STEPS];
    t_word red_rem [0:RED_STEPS];

    // Reflection into [0, pi] and the offsets t - d, t + d.
    logic  flip;
    t_word n_r;
    t_q58  r_t;
    t_tag  r_tag_r;
    t_q58  r_t_p;
    t_q58  r_tm;
    t_q58  r_tp;
    t_tag  r_tag_p;

    // Squares and the cubic factor w = t (t - d)(t + d).
    t_tag  tag_q;
    t_q58  q;
    t_tag  tag_u;
    t_q58  u;
    t_q58  r_t_d1;
    t_q58  r_t_d2;
    t_q58  r_q_d1;
    t_q58  r_q_d2;
    t_tag  tag_w;
    t_q58  w;

    // Horner chain.
    t_tag  hn_tag [0:TERMS];
    t_q58  hn_v   [0:TERMS];
    t_q58  hn_q   [0:TERMS];
    t_q58  hn_w   [0:TERMS];

    // Final product and output rounding.
    t_tag                      tag_s;
    t_q58                      s;
    logic                      s_neg;
    t_word                     s_mag;
    t_word                     s_rnd;
    logic [WORD_W-OUT_SHIFT-1:0] s_q30;
    logic [SINE_W-2:0]         s_sat;
    logic signed [SINE_W-1:0]  n_sine;
    logic signed [SINE_W-1:0]  r_sine;
    logic                      r_strobe;

    // Every cycle is open for a new transaction.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign n_mag = i_angle[ANGLE_W-1] ? $unsigned(-i_angle) : $unsigned(i_angle);

    always_ff @(posedge i_clk) begin
        r_mag      <= n_mag;
        r_tag0.neg <= i_angle[ANGLE_W-1];
        if (!i_rst_n) begin
            r_tag0.valid <= 1'b0;
        end else begin
            r_tag0.valid <= accept;
        end
    end

    // Reduce |angle| (as Q8.56) modulo 2*pi, one restoring step per cell,
    // largest shifted divisor first.
    assign red_tag[0] = r_tag0;
    assign red_rem[0] = {r_mag, {(WORD_W-ANGLE_W){1'b0}}};

    for (genvar g = 0; g < RED_STEPS; g++) begin : g_red
        psin_red_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (red_tag[g]),
            .i_rem   (red_rem[g]),
            .i_div   (TWO_PI_Q56 << (RED_STEPS - 1 - g)),
            .o_tag   (red_tag[g+1]),
            .o_rem   (red_rem[g+1])
        );
    end

    // Fold the upper half turn back onto [0, pi] and flip the sign; exactly
    // pi stays as it is. Then move from Q8.56 to Q5.58.
    assign flip = red_rem[RED_STEPS] > PI_Q56;
    assign n_r  = flip ? TWO_PI_Q56 - red_rem[RED_STEPS] : red_rem[RED_STEPS];

    always_ff @(posedge i_clk) begin
        r_t         <= $signed({n_r[WORD_W-3:0], 2'b00});
        r_tag_r.neg <= red_tag[RED_STEPS].neg ^ flip;
        r_t_p       <= r_t;
        r_tm        <= r_t - D_Q58;
        r_tp        <= r_t + D_Q58;
        r_tag_p.neg <= r_tag_r.neg;
        if (!i_rst_n) begin
            r_tag_r.valid <= 1'b0;
            r_tag_p.valid <= 1'b0;
        end else begin
            r_tag_r.valid <= red_tag[RED_STEPS].valid;
            r_tag_p.valid <= r_tag_r.valid;
        end
    end

    // q = t^2 and u = (t - d)(t + d) side by side.
    psin_mul u_mul_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag_p),
        .i_a     (r_t_p),
        .i_b     (r_t_p),
        .o_tag   (tag_q),
        .o_p     (q)
    );

    psin_mul u_mul_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_tag_p),
        .i_a     (r_tm),
        .i_b     (r_tp),
        .o_tag   (tag_u),
        .o_p     (u)
    );

    // Hold t until u is ready; hold q until w is ready.
    always_ff @(posedge i_clk) begin
        r_t_d1 <= r_t_p;
        r_t_d2 <= r_t_d1;
        r_q_d1 <= q;
        r_q_d2 <= r_q_d1;
    end

    psin_mul u_mul_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag_u),
        .i_a     (r_t_d2),
        .i_b     (u),
        .o_tag   (tag_w),
        .o_p     (w)
    );

    // Horner chain over q; the last TERMS coefficients of the table are used.
    assign hn_tag[0] = tag_w;
    assign hn_v[0]   = '0;
    assign hn_q[0]   = r_q_d2;
    assign hn_w[0]   = w;

    for (genvar g = 0; g < TERMS; g++) begin : g_horner
        localparam int CI = MAX_TERMS - TERMS + g;
        psin_horner_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (hn_tag[g]),
            .i_v     (hn_v[g]),
            .i_q     (hn_q[g]),
            .i_w     (hn_w[g]),
            .i_coef  (psin_coef(COEF_IDX_W'(CI))),
            .o_tag   (hn_tag[g+1]),
            .o_v     (hn_v[g+1]),
            .o_q     (hn_q[g+1]),
            .o_w     (hn_w[g+1])
        );
    end

    psin_mul u_mul_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (hn_tag[TERMS]),
        .i_a     (hn_v[TERMS]),
        .i_b     (hn_w[TERMS]),
        .o_tag   (tag_s),
        .o_p     (s)
    );

    // Round Q5.58 to Q2.30 on the magnitude, clamp to one, apply the sign.
    always_comb begin
        s_neg  = s[WORD_W-1];
        s_mag  = s_neg ? $unsigned(-s) : $unsigned(s);
        s_rnd  = s_mag + (WORD_W'(1) << (OUT_SHIFT - 1));
        s_q30  = s_rnd[WORD_W-1:OUT_SHIFT];
        s_sat  = (s_q30 > (WORD_W-OUT_SHIFT)'(ONE_Q30)) ? ONE_Q30 : s_q30[SINE_W-2:0];
        n_sine = (tag_s.neg ^ s_neg) ? -$signed({1'b0, s_sat}) : $signed({1'b0, s_sat});
    end

    always_ff @(posedge i_clk) begin
        r_sine <= n_sine;
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= tag_s.valid;
        end
    end

    assign o_strobe = r_strobe;
    assign o_sine   = r_sine;

`ifndef SYNTH
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("accepted transaction produced no result");

    a_result_caused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without a matching transaction");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_sine <= SINE_MAX && o_sine >= SINE_MIN))
        else $error("sine outside plus or minus one");

    a_square_units_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tag_q == tag_u)
        else $error("square and offset products out of step");

    a_square_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hn_tag[TERMS].valid |-> !hn_q[TERMS][WORD_W-1])
        else $error("square of the reduced angle went negative");
`endif

endmodule
